// File: src/fpa_pkg.sv
// fpa_pkg: shared widths, command and status codes for the forbidden pattern automaton
// no dependencies
package fpa_pkg;

    localparam int CMD_W = 3;
    localparam int SYM_W = 5;
    localparam int LEN_W = 16;
    localparam int CNT_W = 30;
    localparam int STS_W = 2;

    localparam logic [CNT_W-1:0] PRIME = 30'd1000000007;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_PHASE = 2'd2;
    localparam logic [STS_W-1:0] STS_SYM   = 2'd3;

endpackage

// File: src/fpa_addmod.sv
// fpa_addmod: addition of two residues modulo the prime, the shared arithmetic unit
// depends on fpa_pkg
module fpa_addmod (
    input  logic [fpa_pkg::CNT_W-1:0] i_a,
    input  logic [fpa_pkg::CNT_W-1:0] i_b,
    output logic [fpa_pkg::CNT_W-1:0] o_sum
);

    logic [fpa_pkg::CNT_W:0] sum;

    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = (sum >= {1'b0, fpa_pkg::PRIME})
                 ? fpa_pkg::CNT_W'(sum - {1'b0, fpa_pkg::PRIME})
                 : fpa_pkg::CNT_W'(sum);

endmodule

// File: src/forbidden_pattern_automaton.sv
// forbidden_pattern_automaton: trie load, breadth-first build, scan and string count
// depends on fpa_pkg and fpa_addmod
//
//  channel   signals                                              direction
//  config    i_cfg_valid o_cfg_ready i_cfg_data                   in
//  command   i_valid o_ready i_command i_symbol i_last i_length   in
//  result    o_valid i_ready o_clean o_count o_status             out
//
// one word in flight: o_ready is high only when idle with no result pending
// scan and add read the edge memory, then finish in S_SCAN_DO or S_ADD_DO; clear sweeps the
// edge memory; build steps S_B_RDV, S_B_RDT, S_B_WR per node and symbol, count S_C_ERD,
// S_C_NRD, S_C_NWR per edge per length step, all through the single edge memory read port
// and one modular adder; after reset the edge memory sweep runs first, no word taken
// a pending result holds until i_ready; config writes are taken at any time
module forbidden_pattern_automaton #(
    parameter int MAX_NODES = 256,
    parameter int ALPHABET  = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fpa_pkg::SYM_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fpa_pkg::CMD_W-1:0]   i_command,
    input  logic [fpa_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_last,
    input  logic [fpa_pkg::LEN_W-1:0]   i_length,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_clean,
    output logic [fpa_pkg::CNT_W-1:0]   o_count,
    output logic [fpa_pkg::STS_W-1:0]   o_status
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = NW + 1;
    localparam int EDGES = MAX_NODES * ALPHABET;
    localparam int EAW   = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int SW    = fpa_pkg::SYM_W;
    localparam int KW    = fpa_pkg::CNT_W;

    typedef struct packed {
        logic          valid;
        logic [NW-1:0] idx;
    } t_edge;

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_CLR     = 22'h000002,
        S_ADD_DO  = 22'h000004,
        S_SCAN_DO = 22'h000008,
        S_B_RDV   = 22'h000010,
        S_B_RDT   = 22'h000020,
        S_B_WR    = 22'h000040,
        S_B_POP   = 22'h000080,
        S_B_POPQ  = 22'h000100,
        S_B_POPL  = 22'h000200,
        S_C_INIT  = 22'h000400,
        S_C_STEP  = 22'h000800,
        S_C_ZERO  = 22'h001000,
        S_C_PRD   = 22'h002000,
        S_C_PW    = 22'h004000,
        S_C_ERD   = 22'h008000,
        S_C_NRD   = 22'h010000,
        S_C_NWR   = 22'h020000,
        S_C_CPR   = 22'h040000,
        S_C_CPW   = 22'h080000,
        S_C_SRD   = 22'h100000,
        S_C_SADD  = 22'h200000
    } t_state;

    // storage
    t_edge         edge_mem  [EDGES];
    logic [NW-1:0] link_mem  [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];
    logic [KW-1:0] prev_mem  [MAX_NODES];
    logic [KW-1:0] next_mem  [MAX_NODES];

    t_state                       r_state, n_state;
    logic [SW-1:0]                r_alpha;
    logic [CW-1:0]                r_nodes, n_nodes;
    logic [NW-1:0]                r_cursor, n_cursor;
    logic                         r_dropped, n_dropped;
    logic [NW-1:0]                r_scan, n_scan;
    logic                         r_hit, n_hit;
    logic                         r_built, n_built;
    logic [MAX_NODES-1:0]         r_term, n_term;
    logic [EAW-1:0]               r_ci, n_ci;
    logic                         r_reply, n_reply;
    logic [NW-1:0]                r_u, n_u;
    logic [NW-1:0]                r_f, n_f;
    logic                         r_root, n_root;
    logic [SW-1:0]                r_c, n_c;
    t_edge                        r_v, n_v;
    logic [NW-1:0]                r_head, n_head;
    logic [NW-1:0]                r_tail, n_tail;
    logic [fpa_pkg::LEN_W-1:0]    r_len, n_len;
    logic [fpa_pkg::LEN_W-1:0]    r_step, n_step;
    logic [CW-1:0]                r_n, n_n;
    logic [KW-1:0]                r_w, n_w;
    logic [NW-1:0]                r_d, n_d;
    logic [KW-1:0]                r_acc, n_acc;
    logic [SW-1:0]                r_sym, n_sym;
    logic                         r_last, n_last;
    logic                         r_out_valid, n_out_valid;
    logic                         r_clean, n_clean;
    logic [KW-1:0]                r_count, n_count;
    logic [fpa_pkg::STS_W-1:0]    r_status, n_status;

    t_edge         r_e_rd;
    logic [NW-1:0] r_l_rd;
    logic [NW-1:0] r_q_rd;
    logic [KW-1:0] r_p_rd;
    logic [KW-1:0] r_x_rd;

    // memory ports
    logic          e_we;
    logic          e_wclr;
    logic [NW-1:0] e_wnode, e_rnode;
    logic [SW-1:0] e_wsym, e_rsym;
    t_edge         e_wdata;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic          l_we, q_we, p_we, x_we;
    logic [NW-1:0] l_waddr, l_wdata, l_raddr;
    logic [NW-1:0] q_wdata;
    logic [NW-1:0] p_waddr, p_raddr, x_waddr, x_raddr;
    logic [KW-1:0] p_wdata, x_wdata;

    logic [SW-1:0] eff_a;
    logic [KW-1:0] am_a, am_b, am_sum;
    t_edge         ae;
    logic [NW-1:0] tmp_node;
    logic          tmp_drop;
    logic          tmp_hit;
    logic          c_end;

    fpa_addmod u_addmod (
        .i_a   (am_a),
        .i_b   (am_b),
        .o_sum (am_sum)
    );

    assign eff_a   = (r_alpha > SW'(ALPHABET)) ? SW'(ALPHABET) : r_alpha;
    assign e_raddr = EAW'(EAW'(e_rnode) * EAW'(ALPHABET)) + EAW'(e_rsym);
    assign e_waddr = e_wclr ? r_ci
                   : EAW'(EAW'(e_wnode) * EAW'(ALPHABET)) + EAW'(e_wsym);
    assign c_end   = (SW'(r_c + SW'(1)) >= eff_a);

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid     = r_out_valid;
    assign o_clean     = r_clean;
    assign o_count     = r_count;
    assign o_status    = r_status;

    always_comb begin
        n_state = r_state;     n_nodes = r_nodes;     n_cursor = r_cursor;
        n_dropped = r_dropped; n_scan = r_scan;       n_hit = r_hit;
        n_built = r_built;     n_term = r_term;       n_ci = r_ci;
        n_reply = r_reply;     n_u = r_u;             n_f = r_f;
        n_root = r_root;       n_c = r_c;             n_v = r_v;
        n_head = r_head;       n_tail = r_tail;       n_len = r_len;
        n_step = r_step;       n_n = r_n;             n_w = r_w;
        n_d = r_d;             n_acc = r_acc;         n_sym = r_sym;
        n_last = r_last;       n_clean = r_clean;     n_count = r_count;
        n_status = r_status;
        n_out_valid = r_out_valid && !i_ready;

        e_we = 1'b0; e_wclr = 1'b0; e_wnode = r_u; e_wsym = r_c;
        e_wdata = '0; e_rnode = r_u; e_rsym = r_c;
        l_we = 1'b0; l_waddr = r_v.idx; l_wdata = '0; l_raddr = r_q_rd;
        q_we = 1'b0; q_wdata = r_v.idx;
        p_we = 1'b0; p_waddr = r_n[NW-1:0]; p_wdata = '0; p_raddr = r_n[NW-1:0];
        x_we = 1'b0; x_waddr = r_n[NW-1:0]; x_wdata = '0; x_raddr = r_n[NW-1:0];
        am_a = r_x_rd; am_b = r_w;
        ae = r_e_rd; tmp_node = '0; tmp_drop = 1'b0; tmp_hit = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_sym = i_symbol;
                    n_last = i_last;
                    n_clean = 1'b0;
                    n_count = '0;
                    n_status = fpa_pkg::STS_OK;
                    case (i_command)
                        fpa_pkg::CMD_CLEAR: begin
                            n_nodes = CW'(1);
                            n_cursor = '0;
                            n_scan = '0;
                            n_hit = 1'b0;
                            n_built = 1'b0;
                            n_dropped = 1'b0;
                            n_term = '0;
                            n_ci = '0;
                            n_reply = 1'b1;
                            n_state = S_CLR;
                        end
                        fpa_pkg::CMD_ADD: begin
                            if (r_built) begin
                                n_status = fpa_pkg::STS_PHASE;
                                n_out_valid = 1'b1;
                            end else if (i_symbol >= eff_a || r_dropped) begin
                                if (i_symbol >= eff_a) begin
                                    n_status = fpa_pkg::STS_SYM;
                                    n_dropped = 1'b1;
                                end
                                if (i_last) begin
                                    n_cursor = '0;
                                    n_dropped = 1'b0;
                                end
                                n_out_valid = 1'b1;
                            end else begin
                                e_rnode = r_cursor;
                                e_rsym = i_symbol;
                                n_state = S_ADD_DO;
                            end
                        end
                        fpa_pkg::CMD_BUILD: begin
                            if (r_built) begin
                                n_status = fpa_pkg::STS_PHASE;
                                n_out_valid = 1'b1;
                            end else begin
                                n_u = '0;
                                n_f = '0;
                                n_root = 1'b1;
                                n_c = '0;
                                n_head = '0;
                                n_tail = '0;
                                n_state = S_B_RDV;
                            end
                        end
                        fpa_pkg::CMD_SCAN: begin
                            if (!r_built) begin
                                n_status = fpa_pkg::STS_PHASE;
                                n_out_valid = 1'b1;
                            end else if (i_symbol >= eff_a) begin
                                n_status = fpa_pkg::STS_SYM;
                                if (i_last) begin
                                    n_scan = '0;
                                    n_hit = 1'b0;
                                end
                                n_out_valid = 1'b1;
                            end else begin
                                e_rnode = r_scan;
                                e_rsym = i_symbol;
                                n_state = S_SCAN_DO;
                            end
                        end
                        fpa_pkg::CMD_COUNT: begin
                            if (!r_built) begin
                                n_status = fpa_pkg::STS_PHASE;
                                n_out_valid = 1'b1;
                            end else begin
                                n_len = i_length;
                                n_step = '0;
                                n_n = '0;
                                n_state = S_C_INIT;
                            end
                        end
                        default: begin
                            n_status = fpa_pkg::STS_PHASE;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR: begin
                e_we = 1'b1;
                e_wclr = 1'b1;
                e_wdata = '0;
                n_ci = EAW'(r_ci + EAW'(1));
                if (r_ci == EAW'(EDGES - 1)) begin
                    n_state = S_IDLE;
                    n_out_valid = r_reply;
                end
            end
            S_ADD_DO: begin
                tmp_node = r_cursor;
                tmp_drop = 1'b0;
                if (!ae.valid) begin
                    if (r_nodes >= CW'(MAX_NODES)) begin
                        n_status = fpa_pkg::STS_FULL;
                        tmp_drop = 1'b1;
                    end else begin
                        e_we = 1'b1;
                        e_wnode = r_cursor;
                        e_wsym = r_sym;
                        e_wdata = '{valid: 1'b1, idx: r_nodes[NW-1:0]};
                        tmp_node = r_nodes[NW-1:0];
                        n_nodes = CW'(r_nodes + CW'(1));
                    end
                end else begin
                    tmp_node = ae.idx;
                end
                n_cursor = tmp_node;
                n_dropped = tmp_drop;
                if (r_last) begin
                    if (!tmp_drop && tmp_node != '0) begin
                        n_term[tmp_node] = 1'b1;
                    end
                    n_cursor = '0;
                    n_dropped = 1'b0;
                end
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN_DO: begin
                tmp_node = ae.valid ? ae.idx : '0;
                tmp_hit = r_hit || r_term[tmp_node];
                n_clean = !tmp_hit;
                n_scan = r_last ? '0 : tmp_node;
                n_hit = r_last ? 1'b0 : tmp_hit;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_B_RDV: begin
                e_rnode = r_u;
                e_rsym = r_c;
                n_state = S_B_RDT;
            end
            S_B_RDT: begin
                n_v = r_e_rd;
                e_rnode = r_f;
                e_rsym = r_c;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                tmp_node = (r_root || !ae.valid) ? '0 : ae.idx;
                if (!r_v.valid) begin
                    e_we = 1'b1;
                    e_wnode = r_u;
                    e_wsym = r_c;
                    e_wdata = '{valid: 1'b1, idx: tmp_node};
                end else begin
                    l_we = 1'b1;
                    l_waddr = r_v.idx;
                    l_wdata = tmp_node;
                    if (r_term[tmp_node]) begin
                        n_term[r_v.idx] = 1'b1;
                    end
                    q_we = 1'b1;
                    q_wdata = r_v.idx;
                    n_tail = NW'(r_tail + NW'(1));
                end
                n_c = SW'(r_c + SW'(1));
                n_state = (r_c == SW'(ALPHABET - 1)) ? S_B_POP : S_B_RDV;
            end
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_head = NW'(r_head + NW'(1));
                    n_state = S_B_POPQ;
                end
            end
            S_B_POPQ: begin
                n_u = r_q_rd;
                l_raddr = r_q_rd;
                n_state = S_B_POPL;
            end
            S_B_POPL: begin
                n_f = r_l_rd;
                n_root = 1'b0;
                n_c = '0;
                n_state = S_B_RDV;
            end
            S_C_INIT: begin
                p_we = 1'b1;
                p_wdata = (r_n == '0) ? KW'(1) : '0;
                n_n = CW'(r_n + CW'(1));
                if (CW'(r_n + CW'(1)) == r_nodes) begin
                    n_state = S_C_STEP;
                end
            end
            S_C_STEP: begin
                n_n = '0;
                n_acc = '0;
                n_state = (r_step == r_len) ? S_C_SRD : S_C_ZERO;
            end
            S_C_ZERO: begin
                x_we = 1'b1;
                x_wdata = '0;
                n_n = CW'(r_n + CW'(1));
                if (CW'(r_n + CW'(1)) == r_nodes) begin
                    n_n = '0;
                    n_state = S_C_PRD;
                end
            end
            S_C_PRD: begin
                if (r_n == r_nodes) begin
                    n_n = '0;
                    n_state = S_C_CPR;
                end else begin
                    n_state = S_C_PW;
                end
            end
            S_C_PW: begin
                n_w = r_p_rd;
                n_c = '0;
                if (r_p_rd == '0 || r_term[r_n[NW-1:0]] || eff_a == '0) begin
                    n_n = CW'(r_n + CW'(1));
                    n_state = S_C_PRD;
                end else begin
                    n_state = S_C_ERD;
                end
            end
            S_C_ERD: begin
                e_rnode = r_n[NW-1:0];
                e_rsym = r_c;
                n_state = S_C_NRD;
            end
            S_C_NRD: begin
                tmp_node = ae.valid ? ae.idx : '0;
                n_d = tmp_node;
                x_raddr = tmp_node;
                if (r_term[tmp_node]) begin
                    n_c = SW'(r_c + SW'(1));
                    if (c_end) begin
                        n_n = CW'(r_n + CW'(1));
                        n_state = S_C_PRD;
                    end else begin
                        n_state = S_C_ERD;
                    end
                end else begin
                    n_state = S_C_NWR;
                end
            end
            S_C_NWR: begin
                am_a = r_x_rd;
                am_b = r_w;
                x_we = 1'b1;
                x_waddr = r_d;
                x_wdata = am_sum;
                n_c = SW'(r_c + SW'(1));
                if (c_end) begin
                    n_n = CW'(r_n + CW'(1));
                    n_state = S_C_PRD;
                end else begin
                    n_state = S_C_ERD;
                end
            end
            S_C_CPR: begin
                if (r_n == r_nodes) begin
                    n_step = fpa_pkg::LEN_W'(r_step + fpa_pkg::LEN_W'(1));
                    n_state = S_C_STEP;
                end else begin
                    n_state = S_C_CPW;
                end
            end
            S_C_CPW: begin
                p_we = 1'b1;
                p_wdata = r_x_rd;
                n_n = CW'(r_n + CW'(1));
                n_state = S_C_CPR;
            end
            S_C_SRD: begin
                if (r_n == r_nodes) begin
                    n_count = r_acc;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_C_SADD;
                end
            end
            S_C_SADD: begin
                am_a = r_acc;
                am_b = r_p_rd;
                n_acc = am_sum;
                n_n = CW'(r_n + CW'(1));
                n_state = S_C_SRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            edge_mem[e_waddr] <= e_wdata;
        end
        r_e_rd <= edge_mem[e_raddr];
        if (l_we) begin
            link_mem[l_waddr] <= l_wdata;
        end
        r_l_rd <= link_mem[l_raddr];
        if (q_we) begin
            queue_mem[r_tail] <= q_wdata;
        end
        r_q_rd <= queue_mem[r_head];
        if (p_we) begin
            prev_mem[p_waddr] <= p_wdata;
        end
        r_p_rd <= prev_mem[p_raddr];
        if (x_we) begin
            next_mem[x_waddr] <= x_wdata;
        end
        r_x_rd <= next_mem[x_raddr];
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        r_u <= n_u;       r_f <= n_f;       r_root <= n_root;   r_c <= n_c;
        r_v <= n_v;       r_len <= n_len;   r_step <= n_step;   r_n <= n_n;
        r_w <= n_w;       r_d <= n_d;       r_acc <= n_acc;     r_sym <= n_sym;
        r_last <= n_last; r_clean <= n_clean; r_count <= n_count;
        r_status <= n_status; r_head <= n_head; r_tail <= n_tail;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_alpha <= SW'(26);
            r_nodes <= CW'(1);
            r_cursor <= '0;
            r_dropped <= 1'b0;
            r_scan <= '0;
            r_hit <= 1'b0;
            r_built <= 1'b0;
            r_term <= '0;
            r_ci <= '0;
            r_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_data;
            end
            r_nodes <= n_nodes;
            r_cursor <= n_cursor;
            r_dropped <= n_dropped;
            r_scan <= n_scan;
            r_hit <= n_hit;
            r_built <= n_built;
            r_term <= n_term;
            r_ci <= n_ci;
            r_reply <= n_reply;
            r_out_valid <= n_out_valid;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fpa_pkg::STS_OK) |-> (!o_clean && o_count == '0))
        else $error("error word carries a value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count < fpa_pkg::PRIME))
        else $error("count not reduced");

    a_nodes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes <= CW'(MAX_NODES)) && (r_nodes != '0))
        else $error("node count out of range");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while busy");

endmodule

// File: sim/tb_forbidden_pattern_automaton.sv
// testbench for forbidden_pattern_automaton: directed table then random episodes of
// clear, pattern load, build, scan and count, checked against an in-bench automaton model
// depends on fpa_pkg and the rtl of forbidden_pattern_automaton
module tb_forbidden_pattern_automaton;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int NODES = 256;
    localparam int SYMS  = 26;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int RANDOM_WORDS = 1400;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [LEN_W-1:0] len;
    } word_t;

    typedef struct packed {
        logic             clean;
        logic [CNT_W-1:0] count;
        logic [STS_W-1:0] status;
    } res_t;

    typedef struct {
        bit               wcfg;
        logic [SYM_W-1:0] cfg;
        word_t            w;
        bit               known;
        res_t             r;
    } row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [SYM_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_ready;
    logic [CMD_W-1:0] i_command;
    logic [SYM_W-1:0] i_symbol;
    logic             i_last;
    logic [LEN_W-1:0] i_length;
    logic             o_valid;
    logic             i_ready;
    logic             o_clean;
    logic [CNT_W-1:0] o_count;
    logic [STS_W-1:0] o_status;

    forbidden_pattern_automaton i_dut (.*);

    // automaton model state
    int trie[NODES][SYMS];
    int link[NODES];
    bit mark[NODES];
    int n_nodes, cursor, scan_at, alpha;
    bit hit, built, dropped;

    res_t results_due[$];
    bit   cur_known;
    res_t cur_exp;
    int   mismatches;
    bit   failed;
    bit   hold_req;
    int   burst_left;
    int   words_sent;
    longint cycles;

    function automatic int eff_alpha();
        return alpha > SYMS ? SYMS : alpha;
    endfunction

    function automatic int step_to(int n, int s);
        if (s >= SYMS || trie[n][s] < 0) return 0;
        return trie[n][s];
    endfunction

    function automatic void wipe();
        foreach (trie[n, c]) trie[n][c] = -1;
        foreach (mark[n]) mark[n] = 0;
        foreach (link[n]) link[n] = 0;
        n_nodes = 1; cursor = 0; scan_at = 0;
        hit = 0; built = 0; dropped = 0;
    endfunction

    function automatic void complete_automaton();
        int q[$];
        int u, f, v, t;
        link[0] = 0;
        for (int c = 0; c < SYMS; c++) begin
            v = trie[0][c];
            if (v < 0) trie[0][c] = 0;
            else begin
                link[v] = 0;
                q.push_back(v);
            end
        end
        while (q.size() > 0) begin
            u = q.pop_front();
            f = link[u];
            for (int c = 0; c < SYMS; c++) begin
                v = trie[u][c];
                t = step_to(f, c);
                if (v < 0) trie[u][c] = t;
                else begin
                    link[v] = t;
                    if (mark[t]) mark[v] = 1;
                    q.push_back(v);
                end
            end
        end
        built = 1;
    endfunction

    function automatic longint avoiding_strings(int len);
        longint prev[NODES];
        longint nxt[NODES];
        longint total;
        int d;
        total = 0;
        foreach (prev[n]) prev[n] = 0;
        prev[0] = 1;
        for (int k = 0; k < len; k++) begin
            foreach (nxt[n]) nxt[n] = 0;
            for (int n = 0; n < n_nodes; n++) begin
                if (prev[n] == 0 || mark[n]) continue;
                for (int c = 0; c < eff_alpha(); c++) begin
                    d = step_to(n, c);
                    if (!mark[d]) nxt[d] = (nxt[d] + prev[n]) % PRIME;
                end
            end
            prev = nxt;
        end
        for (int n = 0; n < n_nodes; n++) total = (total + prev[n]) % PRIME;
        return total;
    endfunction

    function automatic logic [STS_W-1:0] load_symbol(int s, bit fin);
        logic [STS_W-1:0] st;
        int e;
        st = STS_OK;
        if (s >= eff_alpha()) begin
            st = STS_SYM;
            dropped = 1;
        end else if (!dropped) begin
            e = trie[cursor][s];
            if (e < 0) begin
                if (n_nodes >= NODES) begin
                    st = STS_FULL;
                    dropped = 1;
                end else begin
                    trie[cursor][s] = n_nodes;
                    cursor = n_nodes;
                    n_nodes++;
                end
            end else cursor = e;
        end
        if (fin) begin
            if (!dropped && cursor != 0) mark[cursor] = 1;
            cursor = 0;
            dropped = 0;
        end
        return st;
    endfunction

    function automatic res_t predict(word_t w);
        res_t r;
        r = '0;
        case (w.cmd)
            CMD_CLEAR: wipe();
            CMD_ADD: begin
                if (built) r.status = STS_PHASE;
                else r.status = load_symbol(w.sym, w.last);
            end
            CMD_BUILD: begin
                if (built) r.status = STS_PHASE;
                else complete_automaton();
            end
            CMD_SCAN: begin
                if (!built) r.status = STS_PHASE;
                else if (w.sym >= eff_alpha()) begin
                    r.status = STS_SYM;
                    if (w.last) begin scan_at = 0; hit = 0; end
                end else begin
                    scan_at = step_to(scan_at, w.sym);
                    if (mark[scan_at]) hit = 1;
                    r.clean = !hit;
                    if (w.last) begin scan_at = 0; hit = 0; end
                end
            end
            CMD_COUNT: begin
                if (!built) r.status = STS_PHASE;
                else r.count = avoiding_strings(w.len);
            end
            default: r.status = STS_PHASE;
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_t got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) alpha = i_cfg_data;
            if (o_valid && i_ready) begin
                got = '{o_clean, o_count, o_status};
                if (results_due.size() == 0) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %p", got);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: clean %0d/%0d count %0d/%0d status %0d/%0d",
                                want.clean, got.clean, want.count, got.count,
                                want.status, got.status);
                    end
                end
            end
            if (i_valid && o_ready) begin
                want = predict('{i_command, i_symbol, i_last, i_length});
                results_due.push_back(cur_known ? cur_exp : want);
            end
        end
    end

    // receiver stall patterns, plus a long hold-off on request
    initial begin
        int mode, span, k;
        i_ready = 0;
        mode = 0; span = 0; k = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 0;
                hold_req = 0;
                repeat (400) @(negedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                k++;
                case (mode)
                    0: i_ready <= 1;
                    1: i_ready <= $urandom_range(0, 1);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (k % 5 != 0);
                endcase
            end
        end
    end

    task automatic send(word_t w, bit known = 0, res_t r = '0);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end else @(negedge i_clk);
        burst_left--;
        i_valid   <= 1;
        i_command <= w.cmd;
        i_symbol  <= w.sym;
        i_last    <= w.last;
        i_length  <= w.len;
        cur_known = known;
        cur_exp   = r;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_alphabet(logic [SYM_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic word_t mk(logic [CMD_W-1:0] c, int s = 0, bit l = 0, int n = 0);
        return '{c, s[SYM_W-1:0], l, n[LEN_W-1:0]};
    endfunction

    function automatic res_t st(logic [STS_W-1:0] s);
        return '{1'b0, '0, s};
    endfunction

    function automatic res_t cl(bit c);
        return '{c, '0, STS_OK};
    endfunction

    function automatic res_t cn(int n);
        return '{1'b0, n[CNT_W-1:0], STS_OK};
    endfunction

    function automatic int pick_sym(int pool);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, pool - 1);
    endfunction

    task automatic episode(bit fill);
        int pool, pats, plen, texts, tlen;
        logic [SYM_W-1:0] a;
        if (fill) write_alphabet(SYMS);
        else if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0: a = 1;
                1: a = SYMS;
                2: a = $urandom_range(27, 31);
                3: a = 0;
                default: a = $urandom_range(1, 26);
            endcase
            write_alphabet(a);
        end
        pool = eff_alpha() < 1 ? 1 : (eff_alpha() < 4 ? eff_alpha() : $urandom_range(2, 4));
        send(mk(CMD_CLEAR));
        if ($urandom_range(0, 2) == 0)
            send(mk($urandom_range(0, 1) ? CMD_SCAN : CMD_COUNT, $urandom_range(0, 31),
                    $urandom_range(0, 1), $urandom_range(0, 65535)));
        if ($urandom_range(0, 4) == 0) send(mk($urandom_range(5, 7), $urandom_range(0, 31)));
        pats = fill ? 45 : $urandom_range(1, 6);
        for (int p = 0; p < pats; p++) begin
            plen = fill ? 6 : $urandom_range(1, 5);
            for (int j = 0; j < plen; j++)
                send(mk(CMD_ADD, fill ? $urandom_range(0, 25) : pick_sym(pool), j == plen - 1));
        end
        send(mk(CMD_BUILD));
        if ($urandom_range(0, 3) == 0) send(mk(CMD_BUILD));
        if ($urandom_range(0, 3) == 0) send(mk(CMD_ADD, $urandom_range(0, 31), 1));
        if ($urandom_range(0, 5) == 0) hold_req = 1;
        texts = $urandom_range(2, 5);
        for (int t = 0; t < texts; t++) begin
            tlen = $urandom_range(1, 10);
            for (int j = 0; j < tlen; j++)
                send(mk(CMD_SCAN, pick_sym(pool), j == tlen - 1));
        end
        for (int k = $urandom_range(1, 2); k > 0; k--)
            send(mk(CMD_COUNT, $urandom_range(0, 31), $urandom_range(0, 1),
                    fill ? $urandom_range(0, 1) : $urandom_range(0, 6)));
        drain();
    endtask

    row_t plan[] = '{
        '{0, 0, mk(CMD_SCAN, 0, 1),        1, st(STS_PHASE)},
        '{0, 0, mk(CMD_COUNT, 0, 0, 65535), 1, st(STS_PHASE)},
        '{0, 0, mk(3'd5),                  1, st(STS_PHASE)},
        '{0, 0, mk(3'd6, 31, 1),           1, st(STS_PHASE)},
        '{0, 0, mk(3'd7),                  1, st(STS_PHASE)},
        '{0, 0, mk(CMD_ADD, 31, 1),        1, st(STS_SYM)},
        '{0, 0, mk(CMD_ADD, 0, 1),         1, st(STS_OK)},
        '{0, 0, mk(CMD_ADD, 25, 0),        1, st(STS_OK)},
        '{0, 0, mk(CMD_ADD, 25, 1),        1, st(STS_OK)},
        '{0, 0, mk(CMD_BUILD),             1, st(STS_OK)},
        '{0, 0, mk(CMD_BUILD),             1, st(STS_PHASE)},
        '{0, 0, mk(CMD_ADD, 1, 1),         1, st(STS_PHASE)},
        '{0, 0, mk(CMD_SCAN, 1, 0),        1, cl(1)},
        '{0, 0, mk(CMD_SCAN, 0, 0),        1, cl(0)},
        '{0, 0, mk(CMD_SCAN, 1, 1),        1, cl(0)},
        '{0, 0, mk(CMD_SCAN, 25, 0),       0, '0},
        '{0, 0, mk(CMD_SCAN, 25, 1),       0, '0},
        '{0, 0, mk(CMD_SCAN, 31, 1),       1, st(STS_SYM)},
        '{0, 0, mk(CMD_COUNT, 0, 0, 0),    1, cn(1)},
        '{0, 0, mk(CMD_COUNT, 0, 0, 1),    1, cn(25)},
        '{0, 0, mk(CMD_COUNT, 0, 0, 3),    0, '0},
        '{1, 1, mk(CMD_CLEAR),             1, st(STS_OK)},
        '{0, 0, mk(CMD_BUILD),             1, st(STS_OK)},
        '{0, 0, mk(CMD_COUNT, 0, 0, 65535), 1, cn(1)},
        '{1, 0, mk(CMD_COUNT, 0, 0, 5),    1, cn(0)}
    };

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0; i_cfg_data = '0;
        i_valid = 0; i_command = '0; i_symbol = '0; i_last = 0; i_length = '0;
        alpha = SYMS;
        wipe();
        mismatches = 0; failed = 0; hold_req = 0;
        burst_left = 0; words_sent = 0; cycles = 0;
        cur_known = 0; cur_exp = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        foreach (plan[i]) begin
            if (plan[i].wcfg) write_alphabet(plan[i].cfg);
            send(plan[i].w, plan[i].known, plan[i].r);
        end
        send(mk(CMD_SCAN, 0, 1), 1, st(STS_SYM));
        write_alphabet(SYMS);

        words_sent = 0;
        episode(1);
        while (words_sent < RANDOM_WORDS) episode($urandom_range(0, 14) == 0);
        write_alphabet(31);
        episode(0);

        drain();
        repeat (50) @(posedge i_clk);
        if (!failed && results_due.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
src/fpa_pkg.sv
src/fpa_addmod.sv
src/forbidden_pattern_automaton.sv
sim/tb_forbidden_pattern_automaton.sv
